// File: rtl/core/fps_pkg.sv
// fps_pkg: shared types, codes and reset values for the fronthaul packet statistics block
// no dependencies; imported by fps_hist, fronthaul_packet_stats and the bench
package fps_pkg;

   // default sizes of the histogram store
   localparam int HIST_BINS_DEF   = 16;
   localparam int COUNT_WIDTH_DEF = 32;

   // ethertype of an 802.1Q tag
   localparam logic [15:0] VLAN_TAG_TYPE = 16'h8100;

   // register reset values
   localparam logic [15:0] ECPRI_TYPE_RST  = 16'haefe;
   localparam logic [7:0]  IQ_MSG_RST      = 8'd0;
   localparam logic [7:0]  CTRL_MSG_RST    = 8'd2;
   localparam logic [8:0]  FULL_BAND_RST   = 9'd273;
   localparam logic [15:0] FIRST_BOUND_RST = 16'd512;
   localparam logic [1:0]  BIN_SHIFT_RST   = 2'd1;

   // register port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ECPRI_ETHER_TYPE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IQ_MESSAGE_TYPE      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONTROL_MESSAGE_TYPE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FULL_BAND_PRBS       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_BIN_BOUND      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIN_SHIFT            = 3'd5;

   // direction codes of the input beat
   localparam logic [1:0] DIR_UL = 2'd0;
   localparam logic [1:0] DIR_DL = 2'd1;

   // result status codes
   localparam logic [1:0] STATUS_IGNORED = 2'd0;
   localparam logic [1:0] STATUS_FIRST   = 2'd1;
   localparam logic [1:0] STATUS_BINNED  = 2'd2;

   // stream codes
   localparam logic [1:0] STREAM_UL_UP   = 2'd0;
   localparam logic [1:0] STREAM_DL_UP   = 2'd1;
   localparam logic [1:0] STREAM_DL_CTRL = 2'd2;
   localparam int         NUM_STREAMS    = 3;

   // input beat
   typedef struct packed {
      logic [15:0] outer_ether_type;
      logic [15:0] inner_ether_type;
      logic [7:0]  message_type;
      logic [1:0]  direction;
      logic [7:0]  prb_field;
      logic        headers_complete;
      logic [63:0] arrival_ns;
   } req_type;

   // result beat
   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  stream;
      logic [3:0]  bin_index;
      logic [63:0] gap_ns;
      logic [63:0] stream_packets;
      logic [63:0] stream_prbs;
      logic [31:0] bin_count;
   } rsp_type;

endpackage

// File: rtl/core/fps_hist.sv
// fps_hist: gap histogram store with per-entry valid bits and read-after-write bypass
// depends on fps_pkg for default sizes and the stream count
module fps_hist #(
   parameter int HIST_BINS   = fps_pkg::HIST_BINS_DEF,
   parameter int COUNT_WIDTH = fps_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 rd_en,
   input  logic [$clog2(3*HIST_BINS)-1:0]       rd_slot,
   input  logic                                 wr_en,
   input  logic [$clog2(3*HIST_BINS)-1:0]       wr_slot,
   output logic [COUNT_WIDTH-1:0]               new_count
);
   import fps_pkg::*;

   localparam int DEPTH  = NUM_STREAMS * HIST_BINS;
   localparam int SLOT_W = $clog2(DEPTH);

   logic [COUNT_WIDTH-1:0] hist_mem [DEPTH];
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic [DEPTH-1:0]       entry_valid_ff;
   logic [DEPTH-1:0]       entry_valid_in;
   logic                   rd_valid_ff;
   logic                   rd_valid_in;
   logic                   fwd_hit_ff;
   logic                   fwd_hit_in;
   logic [COUNT_WIDTH-1:0] fwd_count_ff;
   logic [COUNT_WIDTH-1:0] fwd_count_in;
   logic [COUNT_WIDTH-1:0] old_count;

   // memory array, read data registered on the read beat
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_slot] <= new_count;
      end
      if (rd_en) begin
         rd_data_ff <= hist_mem[rd_slot];
      end
   end

   // valid bits and bypass of the write that lands on the read edge
   always_comb begin
      entry_valid_in = entry_valid_ff;
      rd_valid_in    = rd_valid_ff;
      fwd_hit_in     = fwd_hit_ff;
      fwd_count_in   = fwd_count_ff;
      if (wr_en) begin
         entry_valid_in[wr_slot] = 1'b1;
      end
      if (rd_en) begin
         rd_valid_in  = entry_valid_ff[rd_slot];
         fwd_hit_in   = wr_en && (wr_slot == rd_slot);
         fwd_count_in = new_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
         fwd_hit_ff     <= 1'b0;
      end else begin
         entry_valid_ff <= entry_valid_in;
         rd_valid_ff    <= rd_valid_in;
         fwd_hit_ff     <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_count_ff <= fwd_count_in;
   end

   // incremented bin value, wraps at the counter width
   always_comb begin
      if (fwd_hit_ff) begin
         old_count = fwd_count_ff;
      end else if (rd_valid_ff) begin
         old_count = rd_data_ff;
      end else begin
         old_count = '0;
      end
      new_count = old_count + COUNT_WIDTH'(1);
   end

   // slot width is tied to the depth
   if (SLOT_W < 1) begin : g_bad_depth
      $error("histogram depth too small");
   end

endmodule

// File: rtl/core/fronthaul_packet_stats.sv
// fronthaul_packet_stats: per-stream packet, PRB and inter-arrival statistics of fronthaul frames
// depends on fps_pkg and fps_hist
//
//   channel | ports                                   | role
//   req     | req_valid, req_ready, req_data          | one parsed frame per beat
//   rsp     | rsp_valid, rsp_ready, rsp_data          | one result per frame beat
//   csr     | csr_we, csr_index, csr_wdata            | register write, no wait
//
// one frame per cycle sustained while rsp_ready holds; a beat passes these registers from req to rsp
// (input register, histogram read register, result register)
// the histogram read-modify-write is bypassed so back-to-back frames that hit the same bin count correctly
// synchronous reset clears the stream state and the histogram valid bits
// a stalled rsp holds the result register; the earlier stages keep filling until full
module fronthaul_packet_stats #(
   parameter int HIST_BINS   = fps_pkg::HIST_BINS_DEF,
   parameter int COUNT_WIDTH = fps_pkg::COUNT_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  fps_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output fps_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [fps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fps_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import fps_pkg::*;

   localparam int BIN_W  = $clog2(HIST_BINS);
   localparam int SLOT_W = $clog2(NUM_STREAMS * HIST_BINS);

   // configuration registers
   logic [15:0] ecpri_type_ff,  ecpri_type_in;
   logic [7:0]  iq_msg_ff,      iq_msg_in;
   logic [7:0]  ctrl_msg_ff,    ctrl_msg_in;
   logic [8:0]  full_band_ff,   full_band_in;
   logic [15:0] first_bound_ff, first_bound_in;
   logic [1:0]  bin_shift_ff,   bin_shift_in;

   // stream state
   logic [63:0] last_arrival_ff  [NUM_STREAMS];
   logic [63:0] last_arrival_in  [NUM_STREAMS];
   logic [63:0] packet_counts_ff [NUM_STREAMS];
   logic [63:0] packet_counts_in [NUM_STREAMS];
   logic [63:0] prb_totals_ff    [2];
   logic [63:0] prb_totals_in    [2];

   // pipeline registers
   logic        a_valid_ff, a_valid_in;
   req_type     a_req_ff,   a_req_in;
   logic        b_valid_ff, b_valid_in;
   rsp_type     b_rsp_ff,   b_rsp_in;
   logic [SLOT_W-1:0] b_slot_ff, b_slot_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff,  rsp_data_in;

   // stage a decode
   logic        a_adv;
   logic        b_adv;
   logic [15:0] ether;
   logic        frame_ok;
   logic        is_iq;
   logic        is_ctrl;
   logic        counted;
   logic [1:0]  stream;
   logic [8:0]  prb_inc;
   logic [63:0] cur_last;
   logic [63:0] new_packets;
   logic [63:0] new_prbs;
   logic        first_arrival;
   logic [63:0] gap;
   logic [HIST_BINS-2:0] reach;
   logic [BIN_W-1:0]     bin;
   logic [SLOT_W-1:0]    a_slot;
   logic        a_commit;
   logic        hist_rd_en;
   logic        hist_wr_en;
   logic [COUNT_WIDTH-1:0] hist_count;
   logic [63:0] hist_count_ext;

   // handshake: each stage moves when the one after it is empty or moving
   assign b_adv     = !rsp_valid_ff || rsp_ready;
   assign a_adv     = !b_valid_ff || b_adv;
   assign req_ready = !a_valid_ff || a_adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // register writes
   always_comb begin
      ecpri_type_in  = ecpri_type_ff;
      iq_msg_in      = iq_msg_ff;
      ctrl_msg_in    = ctrl_msg_ff;
      full_band_in   = full_band_ff;
      first_bound_in = first_bound_ff;
      bin_shift_in   = bin_shift_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ECPRI_ETHER_TYPE:     ecpri_type_in  = csr_wdata;
            CSR_IQ_MESSAGE_TYPE:      iq_msg_in      = csr_wdata[7:0];
            CSR_CONTROL_MESSAGE_TYPE: ctrl_msg_in    = csr_wdata[7:0];
            CSR_FULL_BAND_PRBS:       full_band_in   = csr_wdata[8:0];
            CSR_FIRST_BIN_BOUND:      first_bound_in = csr_wdata;
            CSR_BIN_SHIFT:            bin_shift_in   = csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ecpri_type_ff  <= ECPRI_TYPE_RST;
         iq_msg_ff      <= IQ_MSG_RST;
         ctrl_msg_ff    <= CTRL_MSG_RST;
         full_band_ff   <= FULL_BAND_RST;
         first_bound_ff <= FIRST_BOUND_RST;
         bin_shift_ff   <= BIN_SHIFT_RST;
      end else begin
         ecpri_type_ff  <= ecpri_type_in;
         iq_msg_ff      <= iq_msg_in;
         ctrl_msg_ff    <= ctrl_msg_in;
         full_band_ff   <= full_band_in;
         first_bound_ff <= first_bound_in;
         bin_shift_ff   <= bin_shift_in;
      end
   end

   // input register
   always_comb begin
      a_valid_in = a_valid_ff;
      a_req_in   = a_req_ff;
      if (req_ready) begin
         a_valid_in = req_valid;
         if (req_valid) begin
            a_req_in = req_data;
         end
      end
   end

   // frame classification
   always_comb begin
      ether    = (a_req_ff.outer_ether_type == VLAN_TAG_TYPE) ?
                 a_req_ff.inner_ether_type : a_req_ff.outer_ether_type;
      frame_ok = (ether == ecpri_type_ff) && a_req_ff.headers_complete;
      is_iq    = (a_req_ff.message_type == iq_msg_ff);
      is_ctrl  = !is_iq && (a_req_ff.message_type == ctrl_msg_ff);
      counted  = frame_ok &&
                 ((is_iq && (a_req_ff.direction == DIR_UL || a_req_ff.direction == DIR_DL)) ||
                  (is_ctrl && a_req_ff.direction == DIR_DL));
      if (!is_iq) begin
         stream = STREAM_DL_CTRL;
      end else if (a_req_ff.direction == DIR_DL) begin
         stream = STREAM_DL_UP;
      end else begin
         stream = STREAM_UL_UP;
      end
   end

   // counters and gap of the selected stream
   always_comb begin
      prb_inc       = (a_req_ff.prb_field == 8'd0) ? full_band_ff : {1'b0, a_req_ff.prb_field};
      cur_last      = last_arrival_ff[stream];
      new_packets   = packet_counts_ff[stream] + 64'd1;
      new_prbs      = prb_totals_ff[stream[0]] + 64'(prb_inc);
      first_arrival = (cur_last == 64'd0);
      gap           = a_req_ff.arrival_ns - cur_last;
   end

   // log-spaced bin search: bound k is the first bound shifted by k steps,
   // a bound that no longer fits in 64 bits is never reached
   always_comb begin
      logic [127:0] bound;
      logic [6:0]   amt;
      for (int k = 0; k < HIST_BINS - 1; k++) begin
         amt      = 7'(32'(bin_shift_ff) * k);
         bound    = 128'(first_bound_ff) << amt;
         reach[k] = (bound[127:64] == 64'd0) && (gap >= bound[63:0]);
      end
   end

   // priority encode of the first bound not reached
   always_comb begin
      bin = BIN_W'(HIST_BINS - 1);
      for (int k = HIST_BINS - 2; k >= 0; k--) begin
         if (!reach[k]) begin
            bin = BIN_W'(k);
         end
      end
      a_slot = SLOT_W'(stream) * SLOT_W'(HIST_BINS) + SLOT_W'(bin);
   end

   // stream state update as the beat leaves stage a
   assign a_commit = a_valid_ff && a_adv && counted;

   always_comb begin
      last_arrival_in  = last_arrival_ff;
      packet_counts_in = packet_counts_ff;
      prb_totals_in    = prb_totals_ff;
      if (a_commit) begin
         last_arrival_in[stream]  = a_req_ff.arrival_ns;
         packet_counts_in[stream] = new_packets;
         if (is_iq) begin
            prb_totals_in[stream[0]] = new_prbs;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_arrival_ff  <= '{default: '0};
         packet_counts_ff <= '{default: '0};
         prb_totals_ff    <= '{default: '0};
      end else begin
         last_arrival_ff  <= last_arrival_in;
         packet_counts_ff <= packet_counts_in;
         prb_totals_ff    <= prb_totals_in;
      end
   end

   // stage b record
   always_comb begin
      b_valid_in = b_valid_ff;
      b_rsp_in   = b_rsp_ff;
      b_slot_in  = b_slot_ff;
      if (a_adv) begin
         b_valid_in = a_valid_ff;
         b_slot_in  = a_slot;
         b_rsp_in   = '0;
         if (counted) begin
            b_rsp_in.stream         = stream;
            b_rsp_in.stream_packets = new_packets;
            b_rsp_in.stream_prbs    = is_iq ? new_prbs : 64'd0;
            if (first_arrival) begin
               b_rsp_in.status = STATUS_FIRST;
            end else begin
               b_rsp_in.status    = STATUS_BINNED;
               b_rsp_in.bin_index = 4'(bin);
               b_rsp_in.gap_ns    = gap;
            end
         end
      end
   end

   // histogram read on the a to b move, write on the b to result move
   assign hist_rd_en = a_valid_ff && a_adv;
   assign hist_wr_en = b_valid_ff && b_adv && (b_rsp_ff.status == STATUS_BINNED);

   fps_hist #(
      .HIST_BINS   (HIST_BINS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_hist (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (hist_rd_en),
      .rd_slot   (a_slot),
      .wr_en     (hist_wr_en),
      .wr_slot   (b_slot_ff),
      .new_count (hist_count)
   );

   assign hist_count_ext = 64'(hist_count);

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (b_adv) begin
         rsp_valid_in = b_valid_ff;
         rsp_data_in  = b_rsp_ff;
         if (b_rsp_ff.status == STATUS_BINNED) begin
            rsp_data_in.bin_count = hist_count_ext[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_req_ff    <= a_req_in;
      b_rsp_ff    <= b_rsp_in;
      b_slot_ff   <= b_slot_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: tb/fronthaul_packet_stats_tb.sv
// fronthaul_packet_stats_tb: self-checking bench for the fronthaul packet statistics block
// keeps its own copy of the stream counters, prb totals and gap histograms and checks
// every result beat in order; depends on fps_pkg and the fronthaul_packet_stats rtl
module fronthaul_packet_stats_tb;
   import fps_pkg::*;

   localparam int BINS         = HIST_BINS_DEF;
   localparam int QUIET_LIMIT  = 1000;
   localparam int RSP_HOLD     = 60;
   localparam int PHASE_FRAMES = 140;
   localparam int NUM_PHASES   = 6;
   localparam int REPORT_CAP   = 200;

   // codes used only by the directed frames
   localparam logic [1:0] DIR_OTHER = 2'd2;
   localparam logic [7:0] MSG_OTHER = 8'd1;

   // predicted stream state and the queue of result beats still owed by the block
   class frame_stats_board;
      logic [15:0] ecpri_type;
      logic [7:0]  iq_type;
      logic [7:0]  ctrl_type;
      logic [8:0]  full_band;
      logic [15:0] first_bound;
      logic [1:0]  shift;
      logic [63:0] last_seen [NUM_STREAMS];
      logic [63:0] pkt_count [NUM_STREAMS];
      logic [63:0] prb_total [2];
      logic [31:0] bin_hits [NUM_STREAMS*BINS];
      rsp_type     due_stats [$];
      int          errors;

      function new();
         ecpri_type  = ECPRI_TYPE_RST;
         iq_type     = IQ_MSG_RST;
         ctrl_type   = CTRL_MSG_RST;
         full_band   = FULL_BAND_RST;
         first_bound = FIRST_BOUND_RST;
         shift       = BIN_SHIFT_RST;
         foreach (last_seen[i]) begin
            last_seen[i] = '0;
            pkt_count[i] = '0;
         end
         foreach (prb_total[i]) prb_total[i] = '0;
         foreach (bin_hits[i]) bin_hits[i] = '0;
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [15:0] val);
         case (idx)
            CSR_ECPRI_ETHER_TYPE:     ecpri_type  = val;
            CSR_IQ_MESSAGE_TYPE:      iq_type     = val[7:0];
            CSR_CONTROL_MESSAGE_TYPE: ctrl_type   = val[7:0];
            CSR_FULL_BAND_PRBS:       full_band   = val[8:0];
            CSR_FIRST_BIN_BOUND:      first_bound = val;
            CSR_BIN_SHIFT:            shift       = val[1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return due_stats.size();
      endfunction

      // count of shifted bounds that the gap reaches, capped at the last bin
      function int gap_bin(logic [63:0] gap);
         int          bin;
         logic [63:0] bound;
         bin   = 0;
         bound = 64'(first_bound);
         while (bin < BINS - 1 && gap >= bound) begin
            bin++;
            if (bound > ({64{1'b1}} >> shift)) break;
            bound = bound << shift;
         end
         return bin;
      endfunction

      // classify one accepted frame, update the stores and queue its result
      function void account_frame(req_type f);
         rsp_type     r;
         logic [15:0] ether;
         logic [1:0]  s;
         logic [63:0] gap;
         logic        counted;
         int          bin;
         int          slot;
         r       = '0;
         s       = STREAM_UL_UP;
         counted = 1'b0;
         ether   = (f.outer_ether_type == VLAN_TAG_TYPE) ? f.inner_ether_type
                                                         : f.outer_ether_type;
         if (ether == ecpri_type && f.headers_complete) begin
            // iq data wins when both message type registers match
            if (f.message_type == iq_type) begin
               if (f.direction == DIR_UL || f.direction == DIR_DL) begin
                  s       = (f.direction == DIR_UL) ? STREAM_UL_UP : STREAM_DL_UP;
                  counted = 1'b1;
                  prb_total[s] += (f.prb_field == '0) ? 64'(full_band) : 64'(f.prb_field);
                  r.stream_prbs = prb_total[s];
               end
            end else if (f.message_type == ctrl_type && f.direction == DIR_DL) begin
               s       = STREAM_DL_CTRL;
               counted = 1'b1;
            end
         end
         if (counted) begin
            pkt_count[s]    += 64'd1;
            r.stream         = s;
            r.stream_packets = pkt_count[s];
            // a stored time of zero means no earlier arrival on this stream
            if (last_seen[s] == '0) begin
               r.status = STATUS_FIRST;
            end else begin
               gap            = f.arrival_ns - last_seen[s];
               bin            = gap_bin(gap);
               slot           = int'(s) * BINS + bin;
               bin_hits[slot] = bin_hits[slot] + 32'd1;
               r.status       = STATUS_BINNED;
               r.bin_index    = 4'(bin);
               r.gap_ns       = gap;
               r.bin_count    = bin_hits[slot];
            end
            last_seen[s] = f.arrival_ns;
         end
         due_stats.push_back(r);
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= REPORT_CAP)
               $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_stats(rsp_type got);
         rsp_type want;
         if (due_stats.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP)
               $display("%0t result beat with none expected: expected none actual %0h",
                        $time, got);
            return;
         end
         want = due_stats.pop_front();
         check_field("status", 64'(want.status), 64'(got.status));
         check_field("stream", 64'(want.stream), 64'(got.stream));
         check_field("bin_index", 64'(want.bin_index), 64'(got.bin_index));
         check_field("gap_ns", want.gap_ns, got.gap_ns);
         check_field("stream_packets", want.stream_packets, got.stream_packets);
         check_field("stream_prbs", want.stream_prbs, got.stream_prbs);
         check_field("bin_count", 64'(want.bin_count), 64'(got.bin_count));
      endfunction
   endclass

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   frame_stats_board board;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_asks     = 0;
   int          quiet_cycles  = 0;
   logic [63:0] wall_ns       = '0;
   logic [15:0] cur_ecpri     = ECPRI_TYPE_RST;
   logic [7:0]  cur_iq        = IQ_MSG_RST;
   logic [7:0]  cur_ctrl      = CTRL_MSG_RST;

   fronthaul_packet_stats dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // check every accepted result beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_stats(rsp_data);
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold-off whenever one is asked for
   initial begin
      int hold_seen;
      hold_seen = 0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic req_type frame_of(logic [15:0] outer, logic [15:0] inner,
                                        logic [7:0] mtype, logic [1:0] dir,
                                        logic [7:0] prb, logic complete,
                                        logic [63:0] arrival);
      req_type f;
      f.outer_ether_type = outer;
      f.inner_ether_type = inner;
      f.message_type     = mtype;
      f.direction        = dir;
      f.prb_field        = prb;
      f.headers_complete = complete;
      f.arrival_ns       = arrival;
      return f;
   endfunction

   // offer one beat, starting and ending at a falling edge
   task automatic send_frame(input req_type f);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= f;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.account_frame(f);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      board.set_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic program_regs(input logic [15:0] ecpri, input logic [7:0] iq,
                               input logic [7:0] ctrl, input logic [8:0] full_band,
                               input logic [15:0] bound, input logic [1:0] shift);
      write_reg(CSR_ECPRI_ETHER_TYPE, ecpri);
      write_reg(CSR_IQ_MESSAGE_TYPE, 16'(iq));
      write_reg(CSR_CONTROL_MESSAGE_TYPE, 16'(ctrl));
      write_reg(CSR_FULL_BAND_PRBS, 16'(full_band));
      write_reg(CSR_FIRST_BIN_BOUND, bound);
      write_reg(CSR_BIN_SHIFT, 16'(shift));
      csr_we    <= 1'b0;
      cur_ecpri = ecpri;
      cur_iq    = iq;
      cur_ctrl  = ctrl;
   endtask

   task automatic wait_drained();
      while (board.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // mostly well-formed frames on the live streams, some noise
   task automatic make_random_frame(output req_type f);
      int          pick;
      logic [63:0] step;
      f                  = '0;
      f.inner_ether_type = 16'($urandom);
      f.prb_field        = 8'($urandom);
      if ($urandom_range(99) < 15) begin
         f.outer_ether_type = ($urandom_range(3) == 0) ? VLAN_TAG_TYPE : 16'($urandom);
         f.message_type     = 8'($urandom);
         f.direction        = 2'($urandom_range(2));
         f.headers_complete = 1'($urandom);
         f.arrival_ns       = {$urandom, $urandom};
      end else begin
         if ($urandom_range(3) == 0) begin
            f.outer_ether_type = VLAN_TAG_TYPE;
            f.inner_ether_type = cur_ecpri;
         end else begin
            f.outer_ether_type = cur_ecpri;
            if (cur_ecpri == VLAN_TAG_TYPE) f.inner_ether_type = cur_ecpri;
         end
         pick = $urandom_range(9);
         f.message_type = (pick < 5) ? cur_iq : (pick < 9) ? cur_ctrl : 8'($urandom);
         if ($urandom_range(4) == 0) f.direction = 2'($urandom_range(2));
         else if (f.message_type == cur_ctrl) f.direction = DIR_DL;
         else f.direction = 2'($urandom_range(1));
         if ($urandom_range(4) == 0) f.prb_field = '0;
         f.headers_complete = ($urandom_range(19) != 0);
         // arrival: mostly a moving clock with log-spread steps, sometimes zero or wild
         pick = $urandom_range(99);
         if (pick < 3) begin
            f.arrival_ns = '0;
         end else if (pick < 8) begin
            f.arrival_ns = {$urandom, $urandom};
         end else begin
            if (pick < 60) step = 64'($urandom >> $urandom_range(31));
            else step = {$urandom, $urandom} >> $urandom_range(63);
            wall_ns      = wall_ns + step;
            f.arrival_ns = wall_ns;
         end
      end
   endtask

   initial begin
      req_type f;
      board = new();
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed frames under reset register values
      // zero arrival is stored, so the next uplink frame is a first arrival again
      send_frame(frame_of(ECPRI_TYPE_RST, 16'h0000, IQ_MSG_RST, DIR_UL, 8'd0, 1'b1, 64'd0));
      send_frame(frame_of(ECPRI_TYPE_RST, 16'hffff, IQ_MSG_RST, DIR_UL, 8'd1, 1'b1, 64'd100));
      // gaps just under and at the first bound, then a zero gap
      send_frame(frame_of(ECPRI_TYPE_RST, 16'h0000, IQ_MSG_RST, DIR_UL, 8'd255, 1'b1, 64'd611));
      send_frame(frame_of(ECPRI_TYPE_RST, 16'h0000, IQ_MSG_RST, DIR_UL, 8'd0, 1'b1, 64'd1123));
      send_frame(frame_of(ECPRI_TYPE_RST, 16'h0000, IQ_MSG_RST, DIR_UL, 8'd7, 1'b1, 64'd1123));
      // vlan tagged downlink, then a gap near the 64-bit maximum
      send_frame(frame_of(VLAN_TAG_TYPE, ECPRI_TYPE_RST, IQ_MSG_RST, DIR_DL, 8'd128, 1'b1,
                          64'd7));
      send_frame(frame_of(VLAN_TAG_TYPE, ECPRI_TYPE_RST, IQ_MSG_RST, DIR_DL, 8'd0, 1'b1,
                          {64{1'b1}}));
      // control stream, second arrival earlier than the first so the gap wraps
      send_frame(frame_of(ECPRI_TYPE_RST, 16'h0000, CTRL_MSG_RST, DIR_DL, 8'd255, 1'b1, 64'd5));
      send_frame(frame_of(ECPRI_TYPE_RST, 16'h0000, CTRL_MSG_RST, DIR_DL, 8'd0, 1'b1, 64'd3));
      // frames that must be ignored
      send_frame(frame_of(ECPRI_TYPE_RST, 16'h0000, CTRL_MSG_RST, DIR_UL, 8'd9, 1'b1, 64'd50));
      send_frame(frame_of(ECPRI_TYPE_RST, 16'h0000, CTRL_MSG_RST, DIR_OTHER, 8'd9, 1'b1,
                          64'd60));
      send_frame(frame_of(ECPRI_TYPE_RST, 16'h0000, IQ_MSG_RST, DIR_OTHER, 8'd9, 1'b1, 64'd70));
      send_frame(frame_of(ECPRI_TYPE_RST, 16'h0000, IQ_MSG_RST, DIR_UL, 8'd9, 1'b0, 64'd80));
      send_frame(frame_of(VLAN_TAG_TYPE, 16'h0800, IQ_MSG_RST, DIR_UL, 8'd9, 1'b1, 64'd90));
      send_frame(frame_of(16'h0800, ECPRI_TYPE_RST, IQ_MSG_RST, DIR_UL, 8'd9, 1'b1, 64'd95));
      send_frame(frame_of(ECPRI_TYPE_RST, 16'h0000, MSG_OTHER, DIR_DL, 8'd9, 1'b1, 64'd99));
      send_frame(frame_of(16'hffff, 16'hffff, 8'hff, DIR_OTHER, 8'hff, 1'b1, {64{1'b1}}));
      // alternating bit patterns on counted frames
      send_frame(frame_of(ECPRI_TYPE_RST, 16'h5555, IQ_MSG_RST, DIR_UL, 8'haa, 1'b1,
                          64'h5555_5555_5555_5555));
      send_frame(frame_of(VLAN_TAG_TYPE, ECPRI_TYPE_RST, CTRL_MSG_RST, DIR_DL, 8'h55, 1'b1,
                          64'haaaa_aaaa_aaaa_aaaa));
      send_frame(frame_of(ECPRI_TYPE_RST, 16'haaaa, IQ_MSG_RST, DIR_DL, 8'h55, 1'b1,
                          64'haaaa_aaaa_aaaa_aaaa));
      req_valid <= 1'b0;
      wait_drained();

      // random phases, each under its own register setting
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: program_regs(16'($urandom), 8'($urandom), 8'($urandom), 9'd511, 16'd1, 2'd1);
            1: program_regs(16'hffff, 8'hff, 8'hff, 9'd1, 16'hffff, 2'd3);
            2: program_regs(16'h0000, 8'h00, 8'h00, 9'($urandom_range(511, 1)),
                            16'($urandom_range(65535, 1)), 2'd2);
            3: program_regs(VLAN_TAG_TYPE, 8'($urandom), 8'($urandom),
                            9'($urandom_range(511, 1)), 16'($urandom_range(4096, 1)),
                            2'($urandom_range(3, 1)));
            4: program_regs(ECPRI_TYPE_RST, IQ_MSG_RST, CTRL_MSG_RST, FULL_BAND_RST,
                            FIRST_BOUND_RST, BIN_SHIFT_RST);
            default: program_regs(16'($urandom), 8'($urandom), 8'($urandom),
                                  9'($urandom_range(511, 1)), 16'($urandom_range(65535, 1)),
                                  2'($urandom_range(3, 1)));
         endcase
         // idle mix: slow receiver, then slow sender, then full rate
         if (p < 2) begin
            send_idle_pct = 22;
            recv_idle_pct = 71;
         end else if (p < 4) begin
            send_idle_pct = 71;
            recv_idle_pct = 22;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (p == 1 || p == 4) hold_asks++;
         repeat (PHASE_FRAMES) begin
            make_random_frame(f);
            send_frame(f);
         end
         req_valid <= 1'b0;
         wait_drained();
      end

      if (board.errors == 0 && board.pending() == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/fps_pkg.sv
rtl/core/fps_hist.sv
rtl/core/fronthaul_packet_stats.sv
tb/fronthaul_packet_stats_tb.sv
